### rtl/timer_slot_table_assert.svh
// Assertion macros used by the checker file.
`ifndef TIMER_SLOT_TABLE_ASSERT_SVH
`define TIMER_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TST_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tst_pkg.sv
package tst_pkg;

	// Field widths
	localparam int HANDLE_W = 8;
	localparam int LIMIT_W  = 16;
	localparam int COUNT_W  = 17;
	localparam int EV_W     = 3;
	localparam int SLOT_W   = 4;

	localparam logic [COUNT_W-1:0] COUNT_TOP = 17'h1FFFF;

	// Request codes
	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	// Result codes
	localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
	localparam logic [EV_W-1:0] EV_FIRED    = 3'd1;
	localparam logic [EV_W-1:0] EV_ADDED    = 3'd2;
	localparam logic [EV_W-1:0] EV_FULL     = 3'd3;
	localparam logic [EV_W-1:0] EV_REMOVED  = 3'd4;
	localparam logic [EV_W-1:0] EV_NOTFOUND = 3'd5;

	// One stored timer entry
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LIMIT_W-1:0]  limit;
		logic [COUNT_W-1:0]  count;
		logic                one_shot;
	} slot_t;

	// One result beat without its last flag
	typedef struct packed {
		logic [EV_W-1:0]     ev;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0]   slot;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic eval;
		logic flush;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic stall;
		logic out_free;
	} sts_t;

endpackage

### rtl/tst_ctrl.sv
module tst_ctrl #(
	parameter int SLOTS = 10,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  tst_pkg::sts_t sts,
	output tst_pkg::cmd_t cmd,
	output logic [IW-1:0] rd_idx,
	output logic [IW-1:0] ev_idx
);

	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t        state_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] idx_s1;
	logic          v_s1;
	logic          more;

	// Decode commands from the walk position
	always_comb begin
		more      = (idx_q != CW'(SLOTS));
		s_tready  = (state_q == ST_IDLE);
		cmd.load  = (state_q == ST_IDLE) && s_tvalid;
		cmd.rd_en = (state_q == ST_WALK) && !sts.stall && more;
		cmd.eval  = v_s1;
		cmd.flush = (state_q == ST_FLUSH);
		rd_idx    = idx_q[IW-1:0];
		ev_idx    = idx_s1;
	end

	// Step through the slots: read one, evaluate the one read before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			idx_s1  <= '0;
			v_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q   <= '0;
						v_s1    <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!sts.stall) begin
						v_s1 <= more;
						if (more) begin
							idx_s1 <= idx_q[IW-1:0];
							idx_q  <= idx_q + 1'b1;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/tst_dp.sv
module tst_dp #(
	parameter int SLOTS = 10,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tst_pkg::cmd_t cmd,
	input  logic [IW-1:0] rd_idx,
	input  logic [IW-1:0] ev_idx,
	output tst_pkg::sts_t sts,
	input  logic [31:0]   s_tdata,
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,
	output logic [2:0]    m_tuser,
	output logic          m_tlast
);

	tst_pkg::slot_t mem_q [SLOTS];
	tst_pkg::slot_t rd_s1;
	tst_pkg::slot_t wr_data;
	logic           wr_en;

	logic [SLOTS-1:0] used_q;
	logic             used_cur;
	logic             set_used;
	logic             clr_used;

	logic [1:0]                   act_q;
	logic [tst_pkg::HANDLE_W-1:0] hnd_q;
	logic [tst_pkg::LIMIT_W-1:0]  lim_q;
	logic                         os_q;
	logic                         found_q;

	logic [tst_pkg::COUNT_W-1:0] cnt_inc;
	logic                        fire;
	logic                        res;
	tst_pkg::res_t               res_new;
	tst_pkg::res_t               pend_q;
	logic                        pend_v_q;
	tst_pkg::res_t               out_q;
	logic                        out_v_q;
	logic                        out_last_q;
	tst_pkg::res_t               dflt;
	logic                        out_free;
	logic                        commit;
	logic                        out_mid;
	logic                        out_end;

	// Evaluate the slot most recently read
	always_comb begin
		used_cur = used_q[ev_idx];
		cnt_inc  = (rd_s1.count == tst_pkg::COUNT_TOP) ? rd_s1.count
			: rd_s1.count + 17'd1;
		fire     = cnt_inc > {1'b0, rd_s1.limit};
		res      = 1'b0;
		wr_en    = 1'b0;
		set_used = 1'b0;
		clr_used = 1'b0;
		wr_data  = rd_s1;
		res_new.ev     = tst_pkg::EV_NONE;
		res_new.handle = rd_s1.handle;
		res_new.slot   = tst_pkg::SLOT_W'(ev_idx);
		unique case (act_q)
			tst_pkg::ACT_TICK: begin
				if (used_cur) begin
					wr_en         = 1'b1;
					wr_data.count = fire ? '0 : cnt_inc;
					res           = fire;
					res_new.ev    = tst_pkg::EV_FIRED;
					clr_used      = fire && rd_s1.one_shot;
				end
			end
			tst_pkg::ACT_ADD: begin
				if (!used_cur && !found_q) begin
					wr_en            = 1'b1;
					wr_data.handle   = hnd_q;
					wr_data.limit    = lim_q;
					wr_data.count    = '0;
					wr_data.one_shot = os_q;
					set_used         = 1'b1;
					res              = 1'b1;
					res_new.ev       = tst_pkg::EV_ADDED;
					res_new.handle   = hnd_q;
				end
			end
			tst_pkg::ACT_REMOVE: begin
				if (used_cur && (rd_s1.handle == hnd_q)) begin
					clr_used   = 1'b1;
					res        = 1'b1;
					res_new.ev = tst_pkg::EV_REMOVED;
				end
			end
			default: begin
			end
		endcase
	end

	// Closing result when nothing was held back
	always_comb begin
		dflt.handle = '0;
		dflt.slot   = '0;
		unique case (act_q)
			tst_pkg::ACT_ADD:    dflt.ev = tst_pkg::EV_FULL;
			tst_pkg::ACT_REMOVE: dflt.ev = tst_pkg::EV_NOTFOUND;
			default:             dflt.ev = tst_pkg::EV_NONE;
		endcase
	end

	// Hold a new result while the held one cannot move to the output
	always_comb begin
		out_free     = !out_v_q || m_tready;
		sts.stall    = cmd.eval && res && pend_v_q && !out_free;
		sts.out_free = out_free;
		commit       = cmd.eval && !sts.stall;
		out_mid      = commit && res && pend_v_q;
		out_end      = cmd.flush && out_free;
	end

	// Slot memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1 <= mem_q[rd_idx];
		end
		if (commit && wr_en) begin
			mem_q[ev_idx] <= wr_data;
		end
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tuser;
			hnd_q <= s_tdata[7:0];
			lim_q <= s_tdata[23:8];
			os_q  <= s_tdata[24];
		end
	end

	// Control flags: used bits, add done, held and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (commit && set_used) begin
				used_q[ev_idx] <= 1'b1;
			end else if (commit && clr_used) begin
				used_q[ev_idx] <= 1'b0;
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (commit && set_used) begin
				found_q <= 1'b1;
			end
			if (commit && res) begin
				pend_v_q <= 1'b1;
			end else if (out_end) begin
				pend_v_q <= 1'b0;
			end
			if (out_mid || out_end) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Result payload: held beat and output beat
	always_ff @(posedge clk) begin
		if (commit && res) begin
			pend_q <= res_new;
		end
		if (out_mid) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end else if (out_end) begin
			out_q      <= pend_v_q ? pend_q : dflt;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0000, out_q.slot, out_q.handle};
	assign m_tuser  = out_q.ev;
	assign m_tlast  = out_last_q;

endmodule

### rtl/timer_slot_table.sv
// Timer slot table.
// Input stream (s_*): one request per beat. s_tuser carries the request code
// (tick, add, remove by handle); s_tdata carries handle, limit and one-shot.
// Output stream (m_*): one or more result beats per request, m_tlast set on
// the final one. m_tuser carries the result code; m_tdata the handle and
// slot index.
// Each request walks every slot once through the slot memory, one slot per
// cycle while the output does not stall, with one read port and one write
// port. s_tready falls when a request is accepted and rises again in the
// same cycle that its final beat sits in the output register, so a new
// request is not taken before the last one is through.
// A result beat is held until the next result or the walk's end so its last
// flag is known; a stalled receiver freezes the walk when a new result comes
// while the held and output beats are occupied; the output beat holds until taken.
// Reset clears every slot to free and empties the output; no clearing pass
// is needed because a free slot's stored fields are never used.
module timer_slot_table #(
	parameter int SLOTS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // handle[7:0], limit[23:8], one_shot[24], zero
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // fired_handle[7:0], slot[11:8], zero
	output logic [2:0]  m_tuser,  // event_res[2:0]
	output logic        m_tlast
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	tst_pkg::cmd_t cmd;
	tst_pkg::sts_t sts;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] ev_idx;

	tst_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.ev_idx   (ev_idx)
	);

	tst_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.ev_idx   (ev_idx),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### rtl/tst_checker.sv
`include "timer_slot_table_assert.svh"

module tst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// Stalled output beat holds
	`TST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output beat changed under stall")

	// Closing codes stand alone with empty payload
	`TST_ASSERT_SAME(a_dflt_alone, m_tvalid && (m_tuser == tst_pkg::EV_NONE || m_tuser == tst_pkg::EV_FULL || m_tuser == tst_pkg::EV_NOTFOUND), m_tlast && (m_tdata == 16'h0000), "closing result malformed")

	// No new request while a request's results are still open
	`TST_ASSERT_SAME(a_busy_mid, m_tvalid && !m_tlast, !s_tready, "request taken mid-result")

	// A request keeps the block busy past its accepting edge
	`TST_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

bind timer_slot_table tst_checker u_chk (.*);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import tst_pkg::*;

	localparam int SLOTS = 10;
	localparam int RANDOM_REQS = 270;
	localparam int DIRECTED_REQS = 22;
	// Request code the block ignores, answering with a closing EV_NONE beat
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// One result beat as predicted
	typedef struct packed {
		res_t res;
		logic last;
	} result_beat_t;

	// One directed request, with its result typed in where it is obvious
	typedef struct packed {
		logic [1:0]          act;
		logic [HANDLE_W-1:0] hnd;
		logic [LIMIT_W-1:0]  lim;
		logic                os;
		logic                typed;
		res_t                res;
	} req_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // handle[7:0], limit[23:8], one_shot[24], zero
	logic [1:0]  s_tuser = '0;  // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // fired_handle[7:0], slot[11:8], zero
	logic [2:0]  m_tuser;       // event_res[2:0]
	logic        m_tlast;

	// Shadow copy of the slot table
	logic                tbl_used    [SLOTS];
	logic [HANDLE_W-1:0] tbl_handle  [SLOTS];
	logic [LIMIT_W-1:0]  tbl_limit   [SLOTS];
	logic [COUNT_W-1:0]  tbl_count   [SLOTS];
	logic                tbl_oneshot [SLOTS];

	result_beat_t step_beats[$];
	result_beat_t pending_results[$];
	req_row_t     directed_reqs [DIRECTED_REQS];
	logic [7:0]   handle_pool [6];
	int           mismatches = 0;
	bit           calm = 1'b0;

	always #4 clk = ~clk;

	timer_slot_table #(.SLOTS(SLOTS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	function automatic result_beat_t make_beat(logic [EV_W-1:0] ev, logic [7:0] h, int s);
		result_beat_t b;
		b.res.ev = ev;
		b.res.handle = h;
		b.res.slot = s[SLOT_W-1:0];
		b.last = 1'b0;
		return b;
	endfunction

	// Apply one request to the shadow table and collect its results in step_beats
	task automatic timer_table_step(input logic [1:0] act, input logic [7:0] h,
			input logic [15:0] lim, input logic os);
		int i;
		step_beats.delete();
		case (act)
			ACT_TICK: begin
				for (i = 0; i < SLOTS; i++) begin
					if (tbl_used[i]) begin
						if (tbl_count[i] < COUNT_TOP)
							tbl_count[i] = tbl_count[i] + 1'b1;
						if (tbl_count[i] > {1'b0, tbl_limit[i]}) begin
							step_beats.push_back(make_beat(EV_FIRED, tbl_handle[i], i));
							tbl_count[i] = '0;
							if (tbl_oneshot[i]) begin
								tbl_used[i] = 1'b0;
								tbl_limit[i] = '0;
							end
						end
					end
				end
			end
			ACT_ADD: begin
				for (i = 0; i < SLOTS; i++) begin
					if (!tbl_used[i]) begin
						tbl_used[i] = 1'b1;
						tbl_handle[i] = h;
						tbl_limit[i] = lim;
						tbl_count[i] = '0;
						tbl_oneshot[i] = os;
						step_beats.push_back(make_beat(EV_ADDED, h, i));
						break;
					end
				end
				if (step_beats.size() == 0)
					step_beats.push_back(make_beat(EV_FULL, 8'h00, 0));
			end
			ACT_REMOVE: begin
				for (i = 0; i < SLOTS; i++) begin
					if (tbl_used[i] && tbl_handle[i] == h) begin
						tbl_used[i] = 1'b0;
						tbl_limit[i] = '0;
						tbl_count[i] = '0;
						step_beats.push_back(make_beat(EV_REMOVED, h, i));
					end
				end
				if (step_beats.size() == 0)
					step_beats.push_back(make_beat(EV_NOTFOUND, 8'h00, 0));
			end
			default: ;
		endcase
		if (step_beats.size() == 0)
			step_beats.push_back(make_beat(EV_NONE, 8'h00, 0));
		step_beats[step_beats.size() - 1].last = 1'b1;
	endtask

	// Offer one request beat, wait for it to be taken, then queue its results
	task automatic send_request(input logic [1:0] act, input logic [7:0] h,
			input logic [15:0] lim, input logic os, input logic typed, input res_t typed_res);
		int gap;
		result_beat_t b;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {7'd0, os, lim, h};
		do @(posedge clk); while (!s_tready);
		timer_table_step(act, h, lim, os);
		if (typed) begin
			b.res = typed_res;
			b.last = 1'b1;
			pending_results.push_back(b);
		end else begin
			foreach (step_beats[k])
				pending_results.push_back(step_beats[k]);
		end
	endtask

	// Stimulus: reset, directed table, random requests, drain, verdict
	initial begin
		logic [1:0]  act;
		logic [7:0]  h;
		logic [15:0] lim;
		logic        os;
		int          r;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_handle[i] = '0;
			tbl_limit[i] = '0;
			tbl_count[i] = '0;
			tbl_oneshot[i] = 1'b0;
		end
		foreach (handle_pool[i])
			handle_pool[i] = 8'($urandom);
		directed_reqs = '{
			'{ACT_TICK,   8'h00, 16'h0000, 1'b0, 1'b1, '{EV_NONE,     8'h00, 4'd0}},
			'{ACT_REMOVE, 8'hFF, 16'h0000, 1'b0, 1'b1, '{EV_NOTFOUND, 8'h00, 4'd0}},
			'{ACT_SPARE,  8'hFF, 16'hFFFF, 1'b1, 1'b1, '{EV_NONE,     8'h00, 4'd0}},
			'{ACT_ADD,    8'h00, 16'h0000, 1'b1, 1'b1, '{EV_ADDED,    8'h00, 4'd0}},
			'{ACT_ADD,    8'hFF, 16'hFFFF, 1'b0, 1'b1, '{EV_ADDED,    8'hFF, 4'd1}},
			'{ACT_ADD,    8'h5A, 16'h0001, 1'b0, 1'b1, '{EV_ADDED,    8'h5A, 4'd2}},
			'{ACT_TICK,   8'h00, 16'h0000, 1'b0, 1'b0, '0},
			'{ACT_TICK,   8'h00, 16'h0000, 1'b0, 1'b0, '0},
			'{ACT_ADD,    8'h5A, 16'h0000, 1'b0, 1'b0, '0},
			'{ACT_ADD,    8'h5A, 16'h0000, 1'b1, 1'b0, '0},
			'{ACT_ADD,    8'h3C, 16'h0002, 1'b0, 1'b0, '0},
			'{ACT_ADD,    8'h5A, 16'h0000, 1'b0, 1'b0, '0},
			'{ACT_ADD,    8'h3C, 16'h0000, 1'b1, 1'b0, '0},
			'{ACT_ADD,    8'h5A, 16'h0003, 1'b0, 1'b0, '0},
			'{ACT_ADD,    8'h3C, 16'h0001, 1'b1, 1'b0, '0},
			'{ACT_ADD,    8'h5A, 16'h0000, 1'b1, 1'b0, '0},
			'{ACT_ADD,    8'h77, 16'h0004, 1'b0, 1'b1, '{EV_FULL,     8'h00, 4'd0}},
			'{ACT_TICK,   8'h00, 16'h0000, 1'b0, 1'b0, '0},
			'{ACT_TICK,   8'h00, 16'h0000, 1'b0, 1'b0, '0},
			'{ACT_REMOVE, 8'h5A, 16'h0000, 1'b0, 1'b0, '0},
			'{ACT_REMOVE, 8'hFF, 16'h0000, 1'b0, 1'b0, '0},
			'{ACT_TICK,   8'h00, 16'h0000, 1'b0, 1'b0, '0}
		};

		// Hold reset, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_reqs[n])
			send_request(directed_reqs[n].act, directed_reqs[n].hnd, directed_reqs[n].lim,
				directed_reqs[n].os, directed_reqs[n].typed, directed_reqs[n].res);

		// Mostly ticks, adds and removes on a few shared handles, short limits
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			act = (r < 50) ? ACT_TICK : (r < 75) ? ACT_ADD : (r < 95) ? ACT_REMOVE : ACT_SPARE;
			h = ($urandom_range(0, 4) == 0) ? 8'($urandom) : handle_pool[$urandom_range(0, 5)];
			lim = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
			os = 1'($urandom_range(0, 1));
			send_request(act, h, lim, os, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// Drain, then let the block settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** timer_slot_table: PASSED **");
		end else begin
			$display("** timer_slot_table: FAILED **");
		end
		$finish;
	end

	// Receiver: stall a random number of cycles before each beat
	initial begin
		int n;
		forever begin
			n = calm ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	// Compare each taken result beat with the oldest prediction
	always @(posedge clk) begin
		result_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat ev=%0d handle=%02h slot=%0d last=%0b",
					$time, m_tuser, m_tdata[7:0], m_tdata[11:8], m_tlast);
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				if (m_tuser !== e.res.ev) begin
					$display("%0t: event_res expected %0d, got %0d", $time, e.res.ev, m_tuser);
					mismatches++;
				end
				if (m_tdata[7:0] !== e.res.handle) begin
					$display("%0t: fired_handle expected %02h, got %02h",
						$time, e.res.handle, m_tdata[7:0]);
					mismatches++;
				end
				if (m_tdata[11:8] !== e.res.slot) begin
					$display("%0t: slot expected %0d, got %0d", $time, e.res.slot, m_tdata[11:8]);
					mismatches++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: last expected %0b, got %0b", $time, e.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// Give up long after the slowest correct run would have ended
	initial begin
		#2000000;
		$display("** timer_slot_table: FAILED **");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/tst_pkg.sv
rtl/tst_ctrl.sv
rtl/tst_dp.sv
rtl/timer_slot_table.sv
rtl/tst_checker.sv
sim/tb.sv
